// ----- sv/mtoc_pkg.sv -----
// Shared types, constants and the arctangent table for the map-to-odom correction core.
// No dependencies.
package mtoc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int CW           = 40;  // CORDIC x/y width
  localparam int ZW           = 24;  // CORDIC angle width, Q.16 radians
  localparam int MW           = 33;  // multiplier operand width
  localparam int AW           = 68;  // accumulator width

  localparam logic signed [ZW-1:0] ANG_PI      = ZW'(205887);
  localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(102944);
  localparam logic signed [15:0]   HDG_PI      = 16'sd25736;
  localparam logic signed [16:0]   HDG_TWO_PI  = 17'sd51472;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  typedef enum logic [1:0] {
    CMD_ODOM = 2'd0,
    CMD_LOC  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_OFS_X   = 2'd0,
    REG_OFS_Y   = 2'd1,
    REG_HEADING = 2'd2,
    REG_NONE    = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_NUM, S_NUM_W, S_DEN, S_DEN_W, S_ATAN, S_ATAN_W,
    S_ROT, S_ROT_W, S_TX, S_TX_W, S_TY, S_TY_W, S_FIN, S_TROT, S_TROT_W
  } state_e;

  typedef struct packed {
    logic                 start;
    logic                 vec;   // 1: vectoring (atan2), 0: rotation (sin/cos)
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 valid;
    logic                 clear;
    logic                 sub;
    logic signed [MW-1:0] a;
    logic signed [MW-1:0] b;
  } mac_op_t;

  // atan(2^-i) in Q.16 radians
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    r = '0;
    case (idx)
      5'd0:    r = ZW'(51472);
      5'd1:    r = ZW'(30386);
      5'd2:    r = ZW'(16055);
      5'd3:    r = ZW'(8150);
      5'd4:    r = ZW'(4091);
      5'd5:    r = ZW'(2047);
      5'd6:    r = ZW'(1024);
      5'd7:    r = ZW'(512);
      5'd8:    r = ZW'(256);
      5'd9:    r = ZW'(128);
      5'd10:   r = ZW'(64);
      5'd11:   r = ZW'(32);
      5'd12:   r = ZW'(16);
      5'd13:   r = ZW'(8);
      5'd14:   r = ZW'(4);
      5'd15:   r = ZW'(2);
      5'd16:   r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/mtoc_cordic.sv -----
// Iterative CORDIC: vectoring mode for atan2, rotation mode for sin/cos.
// Depends on mtoc_pkg.
module mtoc_cordic import mtoc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cordic_req_t          req_i,
  output logic                 done_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  logic                 run_q, done_q, vec_q, neg_q, zero_q;
  logic [STEP_W-1:0]    step_q;
  logic signed [CW-1:0] x_q, y_q, x_n, y_n, dx, dy;
  logic signed [ZW-1:0] z_q, z_n, z_w, at;
  logic                 dir;

  // One micro-rotation per cycle
  always_comb begin
    dx  = y_q >>> step_q;
    dy  = x_q >>> step_q;
    at  = atan_q16(5'(step_q));
    dir = vec_q ? (y_q > 0) : (z_q < 0);
    if (dir) begin
      x_n = x_q + dx;
      y_n = y_q - dy;
    end else begin
      x_n = x_q - dx;
      y_n = y_q + dy;
    end
    if (dir) z_n = z_q + at;
    else     z_n = z_q - at;
    if (z_n > ANG_PI)       z_w = z_n - (ANG_PI <<< 1);
    else if (z_n < -ANG_PI) z_w = z_n + (ANG_PI <<< 1);
    else                    z_w = z_n;
  end

  // Load, iterate, then post-process on the last step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      vec_q <= req_i.vec;
      if (req_i.vec) begin
        zero_q <= (req_i.x == 0) && (req_i.y == 0);
        neg_q  <= 1'b0;
        if (req_i.x < 0) begin
          x_q <= -req_i.x;
          y_q <= -req_i.y;
          z_q <= (req_i.y >= 0) ? ANG_PI : -ANG_PI;
        end else begin
          x_q <= req_i.x;
          y_q <= req_i.y;
          z_q <= '0;
        end
      end else begin
        zero_q <= 1'b0;
        x_q    <= CORDIC_GAIN;
        y_q    <= '0;
        if (req_i.z > ANG_HALF_PI) begin
          z_q   <= req_i.z - ANG_PI;
          neg_q <= 1'b1;
        end else if (req_i.z < -ANG_HALF_PI) begin
          z_q   <= req_i.z + ANG_PI;
          neg_q <= 1'b1;
        end else begin
          z_q   <= req_i.z;
          neg_q <= 1'b0;
        end
      end
    end else if (run_q) begin
      if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
        x_q <= neg_q ? -x_n : x_n;
        y_q <= neg_q ? -y_n : y_n;
        z_q <= (vec_q && !zero_q) ? z_w : '0;
      end else begin
        x_q <= x_n;
        y_q <= y_n;
        z_q <= z_n;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ----- sv/mtoc_mac.sv -----
// Shared multiply-accumulate: registered product, then accumulate next cycle.
// Depends on mtoc_pkg.
module mtoc_mac import mtoc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mac_op_t              op_i,
  output logic signed [AW-1:0] acc_o
);

  logic                     pv_q, pclr_q, psub_q;
  logic signed [2*MW-1:0]   p_q;
  logic signed [AW-1:0]     acc_q, base, term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else         pv_q <= op_i.valid;
  end

  // Register the product
  always_ff @(posedge clk_i) begin
    p_q    <= op_i.a * op_i.b;
    pclr_q <= op_i.clear;
    psub_q <= op_i.sub;
  end

  always_comb begin
    base = pclr_q ? '0 : acc_q;
    term = AW'(p_q);
  end

  // Accumulate
  always_ff @(posedge clk_i) begin
    if (pv_q) acc_q <= psub_q ? base - term : base + term;
  end

  assign acc_o = acc_q;

endmodule

// ----- sv/map_to_odom_pose_correction_core.sv -----
// Map-to-odom pose correction core: sequencer around a shared CORDIC and MAC.
// An odometry item is stored on transfer and the core stays ready. A localization item
// runs two atan2 passes and one sin/cos pass on the CORDIC, plus 18 multiply terms,
// before the core is ready again. A tick runs one sin/cos pass; the pass starts only
// once the output register is free. Reset clears the offsets, odometry pose, held
// correction and localized flag asynchronously; ticks then use initial-pose registers.
module map_to_odom_pose_correction_core import mtoc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] trans_x_o,
  output logic signed [31:0] trans_y_o,
  output logic signed [15:0] heading_o,
  output logic signed [15:0] rot_z_o,
  output logic signed [15:0] rot_w_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  state_e state_q, state_d;
  logic [1:0] cnt_q;
  logic qsel_q, localized_q, out_valid_q;
  logic signed [31:0] ofs_x_q, ofs_y_q, odom_x_q, odom_y_q, held_x_q, held_y_q;
  logic signed [31:0] loc_x_q, loc_y_q, tk_x_q, tk_y_q;
  logic signed [15:0] ofs_h_q, held_h_q, th_q, h_q;
  logic signed [15:0] oq_x_q, oq_y_q, oq_z_q, oq_w_q, lq_x_q, lq_y_q, lq_z_q, lq_w_q;
  logic signed [15:0] qx, qy, qz, qw, h_init, th_d;
  logic signed [16:0] h_wide;
  logic signed [CW-1:0] num_q;
  logic signed [ZW-1:0] yaw_loc_q, yd_d;
  logic signed [ZW:0]   yd_raw;
  logic signed [ZW-1:0] th_raw;
  logic signed [31:0] out_x_q, out_y_q, tx_sat;
  logic signed [15:0] out_h_q, out_z_q, out_w_q;
  logic signed [AW-1:0] acc;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic cdone, accept, last_term, out_free;
  cordic_req_t creq;
  mac_op_t mop;

  function automatic logic signed [31:0] sat_q16(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    r = (v + (AW'(1) <<< 29)) >>> 30;
    if (r > AW'(32'sh7FFF_FFFF))       return 32'sh7FFF_FFFF;
    else if (r < -(AW'(1) <<< 31))     return 32'sh8000_0000;
    else                               return 32'(r);
  endfunction

  function automatic logic signed [15:0] sat_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + (CW'(1) <<< 14)) >>> 15;
    if (r > CW'(32767))       return 16'sh7FFF;
    else if (r < -CW'(32768)) return 16'sh8000;
    else                      return 16'(r);
  endfunction

  mtoc_cordic u_cordic (
    .clk_i, .rst_ni, .req_i(creq), .done_o(cdone), .x_o(cx), .y_o(cy), .z_o(cz)
  );

  mtoc_mac u_mac (.clk_i, .rst_ni, .op_i(mop), .acc_o(acc));

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign last_term   = (state_q == S_DEN) ? (cnt_q == 2'd3)
                     : (state_q == S_NUM) ? (cnt_q == 2'd1) : (cnt_q == 2'd2);

  // Quaternion source and angle math
  always_comb begin
    qx = qsel_q ? oq_x_q : lq_x_q;
    qy = qsel_q ? oq_y_q : lq_y_q;
    qz = qsel_q ? oq_z_q : lq_z_q;
    qw = qsel_q ? oq_w_q : lq_w_q;
    yd_raw = {yaw_loc_q[ZW-1], yaw_loc_q} - {cz[ZW-1], cz};
    if (yd_raw > (ZW+1)'(ANG_PI))       yd_d = ZW'(yd_raw - ((ZW+1)'(ANG_PI) <<< 1));
    else if (yd_raw < -(ZW+1)'(ANG_PI)) yd_d = ZW'(yd_raw + ((ZW+1)'(ANG_PI) <<< 1));
    else                                yd_d = ZW'(yd_raw);
    th_raw = (yd_d + ZW'(4)) >>> 3;
    if (th_raw > ZW'(HDG_PI))       th_d = HDG_PI;
    else if (th_raw < -ZW'(HDG_PI)) th_d = -HDG_PI;
    else                            th_d = 16'(th_raw);
    if (ofs_h_q > HDG_PI) h_wide = 17'(ofs_h_q) - HDG_TWO_PI;
    else if (ofs_h_q < -HDG_PI) h_wide = 17'(ofs_h_q) + HDG_TWO_PI;
    else h_wide = 17'(ofs_h_q);
    h_init = 16'(h_wide);
    tx_sat = sat_q16(acc);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && cmd_i == CMD_LOC)  state_d = S_NUM;
        if (accept && cmd_i == CMD_TICK) state_d = S_TROT;
      end
      S_NUM:    if (last_term) state_d = S_NUM_W;
      S_NUM_W:  state_d = S_DEN;
      S_DEN:    if (last_term) state_d = S_DEN_W;
      S_DEN_W:  state_d = S_ATAN;
      S_ATAN:   state_d = S_ATAN_W;
      S_ATAN_W: if (cdone) state_d = qsel_q ? S_ROT : S_NUM;
      S_ROT:    state_d = S_ROT_W;
      S_ROT_W:  if (cdone) state_d = S_TX;
      S_TX:     if (last_term) state_d = S_TX_W;
      S_TX_W:   state_d = S_TY;
      S_TY:     if (last_term) state_d = S_TY_W;
      S_TY_W:   state_d = S_FIN;
      S_FIN:    state_d = S_IDLE;
      S_TROT:   if (out_free) state_d = S_TROT_W;
      S_TROT_W: if (cdone) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Unit requests
  always_comb begin
    creq = '0;
    mop  = '0;
    case (state_q)
      S_NUM: begin
        mop.valid = 1'b1;
        mop.clear = (cnt_q == 2'd0);
        mop.a     = MW'(cnt_q == 2'd0 ? qw : qx);
        mop.b     = MW'(cnt_q == 2'd0 ? qz : qy);
      end
      S_DEN: begin
        mop.valid = 1'b1;
        mop.clear = (cnt_q == 2'd0);
        mop.sub   = cnt_q[1];
        case (cnt_q)
          2'd0:    begin mop.a = MW'(qw); mop.b = MW'(qw); end
          2'd1:    begin mop.a = MW'(qx); mop.b = MW'(qx); end
          2'd2:    begin mop.a = MW'(qy); mop.b = MW'(qy); end
          default: begin mop.a = MW'(qz); mop.b = MW'(qz); end
        endcase
      end
      S_ATAN: begin
        creq.start = 1'b1;
        creq.vec   = 1'b1;
        creq.x     = CW'(acc);
        creq.y     = num_q;
      end
      S_ROT: begin
        creq.start = 1'b1;
        creq.z     = ZW'(th_q) <<< 3;
      end
      S_TROT: begin
        creq.start = out_free;
        creq.z     = ZW'(h_q) <<< 2;
      end
      S_TX: begin
        mop.valid = 1'b1;
        mop.clear = (cnt_q == 2'd0);
        mop.sub   = (cnt_q == 2'd1);
        case (cnt_q)
          2'd0:    begin mop.a = MW'(loc_x_q);  mop.b = MW'(1) <<< 30; end
          2'd1:    begin mop.a = MW'(odom_x_q); mop.b = MW'(cx); end
          default: begin mop.a = MW'(odom_y_q); mop.b = MW'(cy); end
        endcase
      end
      S_TY: begin
        mop.valid = 1'b1;
        mop.clear = (cnt_q == 2'd0);
        mop.sub   = (cnt_q != 2'd0);
        case (cnt_q)
          2'd0:    begin mop.a = MW'(loc_y_q);  mop.b = MW'(1) <<< 30; end
          2'd1:    begin mop.a = MW'(odom_x_q); mop.b = MW'(cy); end
          default: begin mop.a = MW'(odom_y_q); mop.b = MW'(cx); end
        endcase
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      qsel_q      <= 1'b0;
      localized_q <= 1'b0;
      out_valid_q <= 1'b0;
      ofs_x_q     <= '0;
      ofs_y_q     <= '0;
      ofs_h_q     <= '0;
      odom_x_q    <= '0;
      odom_y_q    <= '0;
      oq_x_q      <= '0;
      oq_y_q      <= '0;
      oq_z_q      <= '0;
      oq_w_q      <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_h_q    <= '0;
    end else begin
      state_q <= state_d;
      // Advance the term counter inside issue states
      if ((state_q == S_NUM || state_q == S_DEN || state_q == S_TX || state_q == S_TY)
          && !last_term) cnt_q <= cnt_q + 2'd1;
      else cnt_q <= '0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_OFS_X:   ofs_x_q <= cfg_data_i;
          REG_OFS_Y:   ofs_y_q <= cfg_data_i;
          REG_HEADING: ofs_h_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (accept && cmd_i == CMD_ODOM) begin
        odom_x_q <= pos_x_i;
        odom_y_q <= pos_y_i;
        oq_x_q   <= quat_x_i;
        oq_y_q   <= quat_y_i;
        oq_z_q   <= quat_z_i;
        oq_w_q   <= quat_w_i;
      end
      if (accept) qsel_q <= 1'b0;
      if (state_q == S_ATAN_W && cdone) qsel_q <= 1'b1;
      if (state_q == S_TY && cnt_q == 2'd0) held_x_q <= tx_sat;
      if (state_q == S_FIN) begin
        held_y_q    <= tx_sat;
        held_h_q    <= th_q;
        localized_q <= 1'b1;
      end
      // Hold the result until the transfer completes
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == S_TROT_W && state_d == S_IDLE) out_valid_q <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      loc_x_q <= pos_x_i;
      loc_y_q <= pos_y_i;
      lq_x_q  <= quat_x_i;
      lq_y_q  <= quat_y_i;
      lq_z_q  <= quat_z_i;
      lq_w_q  <= quat_w_i;
      tk_x_q  <= localized_q ? held_x_q : ofs_x_q;
      tk_y_q  <= localized_q ? held_y_q : ofs_y_q;
      h_q     <= localized_q ? held_h_q : h_init;
    end
    if (state_q == S_DEN && cnt_q == 2'd0) num_q <= CW'(acc) <<< 1;
    if (state_q == S_ATAN_W && cdone) begin
      if (!qsel_q) yaw_loc_q <= cz;
      else         th_q      <= th_d;
    end
    if (state_q == S_TROT_W && state_d == S_IDLE) begin
      out_x_q <= tk_x_q;
      out_y_q <= tk_y_q;
      out_h_q <= h_q;
      out_z_q <= sat_q15(cy);
      out_w_q <= sat_q15(cx);
    end
  end

  assign out_valid_o = out_valid_q;
  assign trans_x_o   = out_x_q;
  assign trans_y_o   = out_y_q;
  assign heading_o   = out_h_q;
  assign rot_z_o     = out_z_q;
  assign rot_w_o     = out_w_q;

  // Heading of a delivered transform stays within [-pi, pi]
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_o <= HDG_PI && heading_o >= -HDG_PI))
    else $error("heading out of range");

  // CORDIC completes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdone |-> (state_q == S_ATAN_W || state_q == S_ROT_W || state_q == S_TROT_W))
    else $error("unexpected CORDIC completion");

  // Localized flag is set only at the end of a correction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(localized_q) |-> $past(state_q) == S_FIN)
    else $error("localized set outside finish");

  // Neither the MAC nor the CORDIC is requested whenever an item can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mop.valid && !creq.start)
    else $error("unit busy while ready");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for map_to_odom_pose_correction_core: random and directed
// pose, localization and tick transfers, checked against a fixed-point predictor.
// Depends on mtoc_pkg and the core RTL.
module tb;
  import mtoc_pkg::*;

  localparam longint PI_Q16 = 205887;
  localparam longint HALF_PI_Q16 = 102944;
  localparam longint HDG_LIM = 25736;
  localparam longint GAIN_Q30 = 652032874;
  localparam longint Q16_MAX = (longint'(1) << 31) - 1;
  localparam longint Q16_MIN = -(longint'(1) << 31);
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    cmd_e                cmd;
    logic signed [31:0]  px;
    logic signed [31:0]  py;
    logic signed [15:0]  qx;
    logic signed [15:0]  qy;
    logic signed [15:0]  qz;
    logic signed [15:0]  qw;
  } pose_item_t;

  typedef struct {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [15:0] hd;
    logic signed [15:0] rz;
    logic signed [15:0] rw;
  } map_tf_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         cmd_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic signed [15:0] quat_w_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] trans_x_o;
  logic signed [31:0] trans_y_o;
  logic signed [15:0] heading_o;
  logic signed [15:0] rot_z_o;
  logic signed [15:0] rot_w_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  map_to_odom_pose_correction_core dut (.*);

  // Predictor state
  longint atan_lut [24];
  longint ofs_x_reg, ofs_y_reg, heading_reg;
  longint odom_px, odom_py, odom_qx, odom_qy, odom_qz, odom_qw;
  longint corr_x, corr_y, corr_hd;
  bit     have_fix;

  pose_item_t pending_items[$];
  map_tf_t    expected_tf[$];
  pose_item_t cur_item;
  int queued_cnt = 0, accepted_cnt = 0, tick_cnt = 0, fix_cnt = 0, err_cnt = 0;
  int cfg_cnt = 0;
  bit tx_no_idle = 1'b0, rx_no_idle = 1'b0;
  int hold_req = 0, hold_done = 0;
  int tx_gap = 0, rx_gap = 0, rx_hold = 0, quiet_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_q16(longint a);
    if (a > PI_Q16) a -= 2 * PI_Q16;
    else if (a < -PI_Q16) a += 2 * PI_Q16;
    return a;
  endfunction

  // Vectoring CORDIC: angle of (x, y) in Q.16 radians
  function automatic longint vec_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q16 : -PI_Q16;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_lut[i];
      end else begin
        x -= dx; y += dy; z -= atan_lut[i];
      end
    end
    return wrap_q16(z);
  endfunction

  // Rotation CORDIC: Q.30 sine and cosine of a Q.16 angle
  function automatic void rot_sincos(input longint a, output longint s, output longint c);
    longint x, y, dx, dy;
    bit flip;
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (a > HALF_PI_Q16) begin
      a -= PI_Q16; flip = 1'b1;
    end else if (a < -HALF_PI_Q16) begin
      a += PI_Q16; flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= atan_lut[i];
      end else begin
        x += dx; y -= dy; a += atan_lut[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint yaw_of(longint qx, longint qy, longint qz, longint qw);
    return vec_angle(2 * (qw * qz + qx * qy), qw * qw + qx * qx - qy * qy - qz * qz);
  endfunction

  // Advance the predictor by one accepted item, queue the transform a tick emits
  function automatic void correction_predict(pose_item_t it);
    longint d, th, s, c, tx, ty, h;
    map_tf_t tf;
    case (it.cmd)
      CMD_ODOM: begin
        odom_px = it.px; odom_py = it.py;
        odom_qx = it.qx; odom_qy = it.qy; odom_qz = it.qz; odom_qw = it.qw;
      end
      CMD_LOC: begin
        d = wrap_q16(yaw_of(it.qx, it.qy, it.qz, it.qw)
                     - yaw_of(odom_qx, odom_qy, odom_qz, odom_qw));
        th = clamp((d + 4) >>> 3, -HDG_LIM, HDG_LIM);
        rot_sincos(th * 8, s, c);
        tx = longint'(it.px) * (longint'(1) << 30) - odom_px * c + odom_py * s;
        ty = longint'(it.py) * (longint'(1) << 30) - odom_px * s - odom_py * c;
        corr_x = clamp((tx + (longint'(1) << 29)) >>> 30, Q16_MIN, Q16_MAX);
        corr_y = clamp((ty + (longint'(1) << 29)) >>> 30, Q16_MIN, Q16_MAX);
        corr_hd = th;
        have_fix = 1'b1;
        fix_cnt++;
      end
      CMD_TICK: begin
        if (have_fix) begin
          tf.tx = 32'(corr_x); tf.ty = 32'(corr_y); h = corr_hd;
        end else begin
          tf.tx = 32'(ofs_x_reg); tf.ty = 32'(ofs_y_reg); h = heading_reg;
          if (h > HDG_LIM) h -= 2 * HDG_LIM;
          else if (h < -HDG_LIM) h += 2 * HDG_LIM;
        end
        rot_sincos(h * 4, s, c);
        tf.hd = 16'(h);
        tf.rz = 16'(clamp((s + 16384) >>> 15, -32768, 32767));
        tf.rw = 16'(clamp((c + 16384) >>> 15, -32768, 32767));
        expected_tf.push_back(tf);
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_wait(bit no_idle);
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  // Input driver: pop pending items, hold each until its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        correction_predict(cur_item);
        accepted_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          in_valid_i <= 1'b0;
          tx_gap--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          cmd_i    <= cur_item.cmd;
          pos_x_i  <= cur_item.px;
          pos_y_i  <= cur_item.py;
          quat_x_i <= cur_item.qx;
          quat_y_i <= cur_item.qy;
          quat_z_i <= cur_item.qz;
          quat_w_i <= cur_item.qw;
          in_valid_i <= 1'b1;
          tx_gap = draw_wait(tx_no_idle);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each transfer against the oldest expected transform
  always @(posedge clk_i or negedge rst_ni) begin
    map_tf_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        tick_cnt++;
        if (expected_tf.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transform tx=%0d ty=%0d hd=%0d", $time,
                   trans_x_o, trans_y_o, heading_o);
        end else begin
          e = expected_tf.pop_front();
          if (trans_x_o !== e.tx) begin
            err_cnt++;
            $display("%0t: trans_x expected %0d actual %0d", $time, e.tx, trans_x_o);
          end
          if (trans_y_o !== e.ty) begin
            err_cnt++;
            $display("%0t: trans_y expected %0d actual %0d", $time, e.ty, trans_y_o);
          end
          if (heading_o !== e.hd) begin
            err_cnt++;
            $display("%0t: heading expected %0d actual %0d", $time, e.hd, heading_o);
          end
          if (rot_z_o !== e.rz) begin
            err_cnt++;
            $display("%0t: rot_z expected %0d actual %0d", $time, e.rz, rot_z_o);
          end
          if (rot_w_o !== e.rw) begin
            err_cnt++;
            $display("%0t: rot_w expected %0d actual %0d", $time, e.rw, rot_w_o);
          end
        end
        rx_gap = draw_wait(rx_no_idle);
      end
      if (hold_req != hold_done) begin
        rx_hold = 400;
        hold_done++;
      end
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_ready_i <= 1'b0;
        rx_gap--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run after a long stretch with no transfer on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("tb: FAIL");
          $finish;
        end
      end
    end
  end

  task automatic add_item(cmd_e cmd, logic [31:0] px, logic [31:0] py,
                          logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                          logic [15:0] qw);
    pose_item_t it;
    it.cmd = cmd; it.px = px; it.py = py;
    it.qx = qx; it.qy = qy; it.qz = qz; it.qw = qw;
    pending_items.push_back(it);
    queued_cnt++;
  endtask

  // Block until every item has gone in and every transform has come out
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || expected_tf.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; only called while the core is idle
  task automatic write_reg(reg_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_OFS_X:   ofs_x_reg = longint'($signed(data));
      REG_OFS_Y:   ofs_y_reg = longint'($signed(data));
      REG_HEADING: heading_reg = longint'($signed(data[15:0]));
      default: ;
    endcase
    cfg_cnt++;
  endtask

  task automatic add_ticks(int n);
    repeat (n) add_item(CMD_TICK, $urandom, $urandom, 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
  endtask

  // Random item: mostly well-formed poses with planar quaternions
  task automatic add_random();
    int sel;
    logic [31:0] px, py;
    logic [15:0] qx, qy, qz, qw;
    sel = $urandom_range(0, 99);
    px = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 2000000)) - 1000000;
    py = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 2000000)) - 1000000;
    case ($urandom_range(0, 5))
      0: begin
        qx = 16'($urandom); qy = 16'($urandom); qz = 16'($urandom); qw = 16'($urandom);
      end
      1: begin qx = '0; qy = '0; qz = '0; qw = '0; end
      default: begin
        qx = 16'($signed($urandom_range(0, 200)) - 100);
        qy = 16'($signed($urandom_range(0, 200)) - 100);
        qz = 16'($urandom);
        qw = 16'($urandom);
      end
    endcase
    if (sel < 35) add_item(CMD_ODOM, px, py, qx, qy, qz, qw);
    else if (sel < 65) add_item(CMD_LOC, px, py, qx, qy, qz, qw);
    else if (sel < 95) add_item(CMD_TICK, px, py, qx, qy, qz, qw);
    else add_item(CMD_NONE, px, py, qx, qy, qz, qw);
  endtask

  initial begin
    atan_lut = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128, 64, 32,
                 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
    ofs_x_reg = 0; ofs_y_reg = 0; heading_reg = 0;
    odom_px = 0; odom_py = 0; odom_qx = 0; odom_qy = 0; odom_qz = 0; odom_qw = 0;
    corr_x = 0; corr_y = 0; corr_hd = 0; have_fix = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Ticks before any localization use the initial-pose registers
    add_ticks(2);
    wait_idle();
    write_reg(REG_OFS_X, 32'h7fff_ffff);
    write_reg(REG_OFS_Y, 32'h8000_0000);
    write_reg(REG_HEADING, 32'h0000_7fff);
    add_ticks(2);
    add_item(CMD_NONE, '1, '1, '1, '1, '1, '1);
    wait_idle();
    write_reg(REG_OFS_X, 32'h8000_0000);
    write_reg(REG_OFS_Y, 32'h7fff_ffff);
    write_reg(REG_HEADING, 32'hffff_8000);
    write_reg(REG_NONE, 32'h1234_5678);
    add_ticks(2);
    wait_idle();
    foreach (atan_lut[k]) if (k < 4) begin
      write_reg(REG_HEADING, (k == 0) ? 32'd25736 : (k == 1) ? 32'd25737 :
                             (k == 2) ? -32'sd25737 : -32'sd25736);
      add_ticks(1);
      wait_idle();
    end
    write_reg(REG_OFS_X, $urandom);
    write_reg(REG_OFS_Y, $urandom);
    write_reg(REG_HEADING, $urandom);
    add_item(CMD_ODOM, 32'sd65536, -32'sd65536, 0, 0, 16'sd23170, 16'sd23170);
    add_ticks(1);

    // Localization: zero quaternions, extreme fields, before and after odometry
    add_item(CMD_ODOM, 0, 0, 0, 0, 0, 0);
    add_item(CMD_LOC, 32'sd131072, 32'sd65536, 0, 0, 0, 0);
    add_ticks(1);
    add_item(CMD_LOC, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 16'sd32767, 16'sh8000);
    add_ticks(1);
    add_item(CMD_ODOM, 32'h8000_0000, 32'h7fff_ffff, 16'sh8000, 16'sh7fff, 16'sh8000,
             16'sh7fff);
    add_item(CMD_LOC, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 16'sh7fff, 0);
    add_ticks(1);
    add_item(CMD_ODOM, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 16'sd32767, 16'sd1);
    add_item(CMD_LOC, 32'h8000_0000, 32'h8000_0000, 0, 0, -16'sd32767, 16'sd1);
    add_ticks(1);
    add_item(CMD_LOC, 0, 0, 16'sd23170, 16'sd23170, 0, 0);
    add_ticks(1);
    add_item(CMD_NONE, 0, 0, 0, 0, 0, 0);
    add_ticks(1);
    wait_idle();

    // Random part in chunks; the sender pauses for an empty pipeline between chunks
    for (int chunk = 0; chunk < 6; chunk++) begin
      tx_no_idle = (chunk == 2) || (chunk == 4);
      rx_no_idle = (chunk == 4);
      if (chunk == 2) hold_req++;
      if (chunk == 3) begin
        write_reg(REG_OFS_X, $urandom);
        write_reg(REG_OFS_Y, $urandom);
        write_reg(REG_HEADING, $urandom);
      end
      repeat (150) add_random();
      wait_idle();
    end

    $display("tb: %0d items in, %0d localizations, %0d transforms checked, %0d register writes",
             accepted_cnt, fix_cnt, tick_cnt, cfg_cnt);
    $display("tb: %0d mismatches", err_cnt);
    if (err_cnt == 0 && expected_tf.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
